// ===== design/erm_pkg.sv =====
// Package for the XYZ Euler-angle rotation matrix block.
// Holds the arctangent table, fixed-point constants, the sine/cosine item type
// and the rounding and saturation helper.
`default_nettype none
package erm_pkg;

  localparam int TABLE_LEN = 32;
  localparam int XY_W = 34;
  localparam int Z_W = 35;
  localparam int TRIG_W = 19;
  localparam int PROD_W = 2 * TRIG_W;
  localparam int WIDE_W = 58;

  localparam logic signed [Z_W-1:0] Q30_PI = 35'sd3373259426;
  localparam logic signed [Z_W-1:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [Z_W-1:0] Q30_TWO_PI = 35'sd6746518852;
  localparam logic signed [XY_W-1:0] Q30_GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic signed [TRIG_W-1:0] sa;
    logic signed [TRIG_W-1:0] ca;
    logic signed [TRIG_W-1:0] sb;
    logic signed [TRIG_W-1:0] cb;
    logic signed [TRIG_W-1:0] sg;
    logic signed [TRIG_W-1:0] cg;
  } trig_t;

  function automatic logic signed [15:0] fin(input logic signed [WIDE_W-1:0] v, input int s);
    logic signed [WIDE_W-1:0] r;
    r = (v + (58'sd1 <<< (s - 1))) >>> s;
    if (r > 58'sd16384) begin
      r = 58'sd16384;
    end else if (r < -58'sd16384) begin
      r = -58'sd16384;
    end
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/erm_front.sv =====
// Front part: accepts angle items, reduces each angle and runs three CORDIC lanes.
// Depends on erm_pkg for the table, constants and the trig_t item.
`default_nettype none
module erm_front import erm_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  signed [15:0]  in_angle_x,
  input  wire  signed [15:0]  in_angle_y,
  input  wire  signed [15:0]  in_angle_z,
  output logic                trig_valid,
  input  wire                 trig_ready,
  output trig_t               trig_data
);

  localparam int N = CORDIC_STAGES;

  logic                    v_r   [0:N+1];
  logic                    rdy   [0:N+2];
  logic signed [XY_W-1:0]  x_r   [0:N][0:2];
  logic signed [XY_W-1:0]  y_r   [0:N][0:2];
  logic signed [Z_W-1:0]   z_r   [0:N][0:2];
  logic                    neg_r [0:N][0:2];
  logic signed [15:0]      ang   [0:2];
  trig_t                   out_r;

  assign ang[0] = in_angle_x;
  assign ang[1] = in_angle_y;
  assign ang[2] = in_angle_z;

  assign rdy[N+2] = trig_ready;
  assign in_stall = !rdy[0];
  assign trig_valid = v_r[N+1];
  assign trig_data = out_r;

  genvar k, l;
  generate
    for (k = 0; k <= N + 1; k++) begin : g_ctl
      logic v_prev;
      if (k == 0) begin : g_src
        assign v_prev = in_valid;
      end else begin : g_src
        assign v_prev = v_r[k-1];
      end
      assign rdy[k] = !v_r[k] || rdy[k+1];
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_r[k] <= v_prev;
        end
      end
    end

    for (l = 0; l < 3; l++) begin : g_lane
      logic signed [Z_W-1:0] z0, z1, z_nxt;
      logic                  neg_nxt;
      always_comb begin
        z0 = Z_W'(ang[l]) <<< 18;
        if (z0 > Q30_PI) begin
          z1 = z0 - Q30_TWO_PI;
        end else if (z0 < -Q30_PI) begin
          z1 = z0 + Q30_TWO_PI;
        end else begin
          z1 = z0;
        end
        neg_nxt = 1'b1;
        if (z1 > Q30_HALF_PI) begin
          z_nxt = z1 - Q30_PI;
        end else if (z1 < -Q30_HALF_PI) begin
          z_nxt = z1 + Q30_PI;
        end else begin
          z_nxt = z1;
          neg_nxt = 1'b0;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[0]) begin
          x_r[0][l] <= Q30_GAIN;
          y_r[0][l] <= '0;
          z_r[0][l] <= z_nxt;
          neg_r[0][l] <= neg_nxt;
        end
      end

      for (k = 0; k < N; k++) begin : g_stage
        logic signed [Z_W-1:0] at;
        assign at = signed'({3'b000, ATAN_Q30[k]});
        always_ff @(posedge clk) begin
          if (rdy[k+1]) begin
            neg_r[k+1][l] <= neg_r[k][l];
            if (!z_r[k][l][Z_W-1]) begin
              x_r[k+1][l] <= x_r[k][l] - (y_r[k][l] >>> k);
              y_r[k+1][l] <= y_r[k][l] + (x_r[k][l] >>> k);
              z_r[k+1][l] <= z_r[k][l] - at;
            end else begin
              x_r[k+1][l] <= x_r[k][l] + (y_r[k][l] >>> k);
              y_r[k+1][l] <= y_r[k][l] - (x_r[k][l] >>> k);
              z_r[k+1][l] <= z_r[k][l] + at;
            end
          end
        end
      end
    end
  endgenerate

  logic signed [XY_W-1:0] xf [0:2];
  logic signed [XY_W-1:0] yf [0:2];
  logic signed [XY_W-1:0] cr [0:2];
  logic signed [XY_W-1:0] sr [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xf[i] = neg_r[N][i] ? -x_r[N][i] : x_r[N][i];
      yf[i] = neg_r[N][i] ? -y_r[N][i] : y_r[N][i];
      cr[i] = (xf[i] + 34'sd8192) >>> 14;
      sr[i] = (yf[i] + 34'sd8192) >>> 14;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[N+1]) begin
      out_r.sa <= sr[0][TRIG_W-1:0];
      out_r.ca <= cr[0][TRIG_W-1:0];
      out_r.sb <= sr[1][TRIG_W-1:0];
      out_r.cb <= cr[1][TRIG_W-1:0];
      out_r.sg <= sr[2][TRIG_W-1:0];
      out_r.cg <= cr[2][TRIG_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== design/erm_fifo.sv =====
// Short queue between the front and back parts of the rotation matrix block.
// Depends on erm_pkg for the trig_t item.
`default_nettype none
module erm_fifo import erm_pkg::*; (
  input  wire    clk,
  input  wire    rst_n,
  input  wire    wr_valid,
  output logic   wr_ready,
  input  trig_t  wr_data,
  output logic   rd_valid,
  input  wire    rd_ready,
  output trig_t  rd_data
);

  trig_t       mem [0:3];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  cnt_r;
  logic        push, pop;

  assign wr_ready = (cnt_r != 3'd4);
  assign rd_valid = (cnt_r != 3'd0);
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 2'd1;
      end
      if (pop) begin
        rp_r <= rp_r + 2'd1;
      end
      cnt_r <= cnt_r + {2'b00, push} - {2'b00, pop};
    end
  end

endmodule
`default_nettype wire

// ===== design/erm_back.sv =====
// Back part: forms the nine matrix entries from sines and cosines in three stages.
// Depends on erm_pkg for trig_t, the widths and the rounding helper.
`default_nettype none
module erm_back import erm_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                trig_valid,
  output logic               trig_ready,
  input  trig_t              trig_data,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [15:0] out_row0_col0,
  output logic signed [15:0] out_row0_col1,
  output logic signed [15:0] out_row0_col2,
  output logic signed [15:0] out_row1_col0,
  output logic signed [15:0] out_row1_col1,
  output logic signed [15:0] out_row1_col2,
  output logic signed [15:0] out_row2_col0,
  output logic signed [15:0] out_row2_col1,
  output logic signed [15:0] out_row2_col2
);

  logic v1_r, v2_r, v3_r, rdy1, rdy2, rdy3;
  logic signed [PROD_W-1:0] cbcg1_r, cbsg1_r, sacb1_r, cacb1_r, sasb1_r, casb1_r;
  logic signed [PROD_W-1:0] casg1_r, sasg1_r, cacg1_r, sacg1_r;
  logic signed [TRIG_W-1:0] cg1_r, sg1_r, sb1_r;
  logic signed [PROD_W-1:0] cbcg2_r, cbsg2_r, sacb2_r, cacb2_r;
  logic signed [PROD_W-1:0] casg2_r, sasg2_r, cacg2_r, sacg2_r;
  logic signed [WIDE_W-1:0] t0_r, t1_r, t2_r, t3_r;
  logic signed [TRIG_W-1:0] sb2_r;

  assign rdy3 = !v3_r || !out_stall;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign trig_ready = rdy1;
  assign out_valid = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= trig_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      cbcg1_r <= trig_data.cb * trig_data.cg;
      cbsg1_r <= trig_data.cb * trig_data.sg;
      sacb1_r <= trig_data.sa * trig_data.cb;
      cacb1_r <= trig_data.ca * trig_data.cb;
      sasb1_r <= trig_data.sa * trig_data.sb;
      casb1_r <= trig_data.ca * trig_data.sb;
      casg1_r <= trig_data.ca * trig_data.sg;
      sasg1_r <= trig_data.sa * trig_data.sg;
      cacg1_r <= trig_data.ca * trig_data.cg;
      sacg1_r <= trig_data.sa * trig_data.cg;
      cg1_r <= trig_data.cg;
      sg1_r <= trig_data.sg;
      sb1_r <= trig_data.sb;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      t0_r <= WIDE_W'(sasb1_r) * WIDE_W'(cg1_r);
      t1_r <= WIDE_W'(casb1_r) * WIDE_W'(cg1_r);
      t2_r <= WIDE_W'(sasb1_r) * WIDE_W'(sg1_r);
      t3_r <= WIDE_W'(casb1_r) * WIDE_W'(sg1_r);
      cbcg2_r <= cbcg1_r;
      cbsg2_r <= cbsg1_r;
      sacb2_r <= sacb1_r;
      cacb2_r <= cacb1_r;
      casg2_r <= casg1_r;
      sasg2_r <= sasg1_r;
      cacg2_r <= cacg1_r;
      sacg2_r <= sacg1_r;
      sb2_r <= sb1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_row0_col0 <= fin(WIDE_W'(cbcg2_r), 18);
      out_row0_col1 <= fin(t0_r - (WIDE_W'(casg2_r) <<< 16), 34);
      out_row0_col2 <= fin(t1_r + (WIDE_W'(sasg2_r) <<< 16), 34);
      out_row1_col0 <= fin(WIDE_W'(cbsg2_r), 18);
      out_row1_col1 <= fin(t2_r + (WIDE_W'(cacg2_r) <<< 16), 34);
      out_row1_col2 <= fin(t3_r - (WIDE_W'(sacg2_r) <<< 16), 34);
      out_row2_col0 <= fin(-WIDE_W'(sb2_r), 2);
      out_row2_col1 <= fin(WIDE_W'(sacb2_r), 18);
      out_row2_col2 <= fin(WIDE_W'(cacb2_r), 18);
    end
  end

endmodule
`default_nettype wire

// ===== design/euler_xyz_rotation_matrix.sv =====
// XYZ Euler-angle rotation matrix: CORDIC front, four-entry queue, product back end.
// Throughput is one item per cycle while out_stall is low; each CORDIC iteration is one pipeline stage.
// Synchronous active-low reset clears all valid flags and the queue pointers.
// Depends on erm_pkg, erm_front, erm_fifo and erm_back.
`default_nettype none
module euler_xyz_rotation_matrix import erm_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  signed [15:0] in_angle_x,
  input  wire  signed [15:0] in_angle_y,
  input  wire  signed [15:0] in_angle_z,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [15:0] out_row0_col0,
  output logic signed [15:0] out_row0_col1,
  output logic signed [15:0] out_row0_col2,
  output logic signed [15:0] out_row1_col0,
  output logic signed [15:0] out_row1_col1,
  output logic signed [15:0] out_row1_col2,
  output logic signed [15:0] out_row2_col0,
  output logic signed [15:0] out_row2_col1,
  output logic signed [15:0] out_row2_col2
);

  logic  f_valid, f_ready, b_valid, b_ready;
  trig_t f_data, b_data;

  erm_front #(.CORDIC_STAGES(CORDIC_STAGES)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_angle_x(in_angle_x), .in_angle_y(in_angle_y), .in_angle_z(in_angle_z),
    .trig_valid(f_valid), .trig_ready(f_ready), .trig_data(f_data)
  );

  erm_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  erm_back u_back (
    .clk(clk), .rst_n(rst_n),
    .trig_valid(b_valid), .trig_ready(b_ready), .trig_data(b_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_row0_col0(out_row0_col0), .out_row0_col1(out_row0_col1),
    .out_row0_col2(out_row0_col2), .out_row1_col0(out_row1_col0),
    .out_row1_col1(out_row1_col1), .out_row1_col2(out_row1_col2),
    .out_row2_col0(out_row2_col0), .out_row2_col1(out_row2_col1),
    .out_row2_col2(out_row2_col2)
  );

endmodule
`default_nettype wire

// ===== tb/euler_xyz_rotation_matrix_tb.sv =====
// Testbench for euler_xyz_rotation_matrix: drives angle triples and checks the nine
// matrix entries against a fixed-point CORDIC predictor kept in this file.
// Depends on erm_pkg and the euler_xyz_rotation_matrix RTL.
`timescale 1ns / 1ps
module euler_xyz_rotation_matrix_tb;
  import erm_pkg::*;

  localparam int STAGES = 16;
  localparam int LATENCY = STAGES + 5;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint GAIN_Q30 = 64'sd652032874;

  typedef struct {
    logic signed [15:0] m [9];
  } matrix_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] in_angle_x;
  logic signed [15:0] in_angle_y;
  logic signed [15:0] in_angle_z;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] out_m [9];

  matrix_t expected_matrices [$];
  int mismatches;
  int hold_cycles;
  bit random_stall;
  bit random_gaps;

  euler_xyz_rotation_matrix #(.CORDIC_STAGES(STAGES)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_angle_x(in_angle_x), .in_angle_y(in_angle_y), .in_angle_z(in_angle_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_row0_col0(out_m[0]), .out_row0_col1(out_m[1]), .out_row0_col2(out_m[2]),
    .out_row1_col0(out_m[3]), .out_row1_col1(out_m[4]), .out_row1_col2(out_m[5]),
    .out_row2_col0(out_m[6]), .out_row2_col1(out_m[7]), .out_row2_col2(out_m[8])
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("euler_xyz_rotation_matrix_tb: done, errors");
    $finish;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic void trig_of(logic signed [15:0] angle, output longint s16,
                                  output longint c16);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(angle) * 262144;
    x = GAIN_Q30;
    y = 0;
    flip = 0;
    if (z > PI_Q30) z -= TWO_PI_Q30;
    else if (z < -PI_Q30) z += TWO_PI_Q30;
    if (z > HALF_PI_Q30) begin
      z -= PI_Q30;
      flip = 1;
    end else if (z < -HALF_PI_Q30) begin
      z += PI_Q30;
      flip = 1;
    end
    for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_Q30[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_Q30[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c16 = round_q(x, 14);
    s16 = round_q(y, 14);
  endfunction

  function automatic logic signed [15:0] clamp_entry(longint v, int s);
    longint r;
    r = round_q(v, s);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic matrix_t rotation_of(logic signed [15:0] ax, logic signed [15:0] ay,
                                          logic signed [15:0] az);
    longint sa, ca, sb, cb, sg, cg;
    matrix_t r;
    trig_of(ax, sa, ca);
    trig_of(ay, sb, cb);
    trig_of(az, sg, cg);
    r.m[0] = clamp_entry(cb * cg, 18);
    r.m[1] = clamp_entry(sa * sb * cg - ca * sg * 65536, 34);
    r.m[2] = clamp_entry(ca * sb * cg + sa * sg * 65536, 34);
    r.m[3] = clamp_entry(cb * sg, 18);
    r.m[4] = clamp_entry(sa * sb * sg + ca * cg * 65536, 34);
    r.m[5] = clamp_entry(ca * sb * sg - sa * cg * 65536, 34);
    r.m[6] = clamp_entry(-sb, 2);
    r.m[7] = clamp_entry(sa * cb, 18);
    r.m[8] = clamp_entry(ca * cb, 18);
    return r;
  endfunction

  task automatic send_angles(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az);
    int gap;
    gap = random_gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_angle_x <= ax;
    in_angle_y <= ay;
    in_angle_z <= az;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_matrices.push_back(rotation_of(ax, ay, az));
  endtask

  initial begin
    int wait_left;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 0;
        @(posedge clk);
      end else if (random_stall && wait_left == 0) begin
        wait_left = $urandom_range(0, 6);
        out_stall <= (wait_left != 0);
        @(posedge clk);
      end else begin
        if (wait_left > 0) wait_left--;
        out_stall <= (wait_left != 0);
        @(posedge clk);
      end
    end
  end

  initial begin
    matrix_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_matrices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item");
        end else begin
          want = expected_matrices.pop_front();
          for (int k = 0; k < 9; k++) begin
            if (out_m[k] !== want.m[k]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("entry %0d: expected %0d, got %0d", k, want.m[k], out_m[k]);
            end
          end
        end
      end
    end
  end

  task automatic test_extremes();
    logic signed [15:0] corners [8];
    corners = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd6434, -16'sd6434,
                16'sd12868, -16'sd12868};
    foreach (corners[i]) send_angles(corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]);
    send_angles(16'sd6434, 16'sd6434, 16'sd6434);
    send_angles(-16'sd6434, 16'sd0, 16'sd6433);
    send_angles(16'sd0, 16'sd0, 16'sd0);
    send_angles(16'sh5555, 16'shAAAA, 16'sh5555);
    send_angles(16'shAAAA, 16'sh5555, 16'shAAAA);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_angles(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    for (int i = 0; i < 60; i++) send_angles(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_angle_x = 0;
    in_angle_y = 0;
    in_angle_z = 0;
    mismatches = 0;
    hold_cycles = 0;
    random_stall = 0;
    random_gaps = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_extremes();
    test_random(100);
    random_stall = 1;
    random_gaps = 1;
    test_random(300);
    random_gaps = 0;
    test_backpressure();
    random_stall = 0;
    test_random(40);
    in_valid <= 0;
    while (expected_matrices.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("euler_xyz_rotation_matrix_tb: done, clean");
    end else begin
      $display("euler_xyz_rotation_matrix_tb: done, errors");
    end
    $finish;
  end
endmodule
